// ===== sv/bsps_pkg.sv =====
// ----------------------------------------------------------------------------
// bsps_pkg
// Shared types, register map and operation codes of the bit-sliced
// predicate scan.
// ----------------------------------------------------------------------------
package bsps_pkg;

	// Number of lanes in one segment; lanes at and above it are always cleared.
	localparam int LANES = 64;
	// Largest number of bit slices per code.
	localparam int MAX_CODE_BITS = 32;

	localparam int SLICE_W = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
	localparam int WORD_W  = 64;
	localparam int VALID_W = 7;
	localparam int LIT_W   = 32;
	localparam int CW_W    = 6;
	localparam int ADDR_W  = 5;
	localparam int PDATA_W = 32;

	localparam logic [CW_W-1:0] CODE_WIDTH_RESET = CW_W'(MAX_CODE_BITS);

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_COMPARE_OP    = 3'd0;
	localparam logic [2:0] REG_COMBINE_OP    = 3'd1;
	localparam logic [2:0] REG_LITERAL_VALUE = 3'd2;
	localparam logic [2:0] REG_CODE_WIDTH    = 3'd3;
	localparam logic [2:0] REG_SOURCE_SELECT = 3'd4;

	// Comparator codes.
	localparam logic [2:0] CMP_LT = 3'd0;
	localparam logic [2:0] CMP_GT = 3'd1;
	localparam logic [2:0] CMP_LE = 3'd2;
	localparam logic [2:0] CMP_GE = 3'd3;
	localparam logic [2:0] CMP_EQ = 3'd4;
	localparam logic [2:0] CMP_NE = 3'd5;

	// Combine codes.
	localparam logic [1:0] CMB_SET = 2'd0;
	localparam logic [1:0] CMB_AND = 2'd1;
	localparam logic [1:0] CMB_OR  = 2'd2;

	typedef struct packed {
		logic [2:0]       compare_op;
		logic [1:0]       combine_op;
		logic [LIT_W-1:0] literal_value;
		logic [CW_W-1:0]  code_width;
		logic             source_select;
	} cfg_t;

endpackage

// ===== sv/bsps_regs.sv =====
// ----------------------------------------------------------------------------
// bsps_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module bsps_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsps_pkg::ADDR_W-1:0]    paddr,
	input  logic [bsps_pkg::PDATA_W-1:0]   pwdata,
	output logic [bsps_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output bsps_pkg::cfg_t                 cfg
);
	import bsps_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_index;
	logic       wr_en;

	assign reg_index = paddr[ADDR_W-1:2];
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.compare_op    <= CMP_LT;
			cfg_q.combine_op    <= CMB_SET;
			cfg_q.literal_value <= '0;
			cfg_q.code_width    <= CODE_WIDTH_RESET;
			cfg_q.source_select <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_index)
				REG_COMPARE_OP:    cfg_q.compare_op    <= pwdata[2:0];
				REG_COMBINE_OP:    cfg_q.combine_op    <= pwdata[1:0];
				REG_LITERAL_VALUE: cfg_q.literal_value <= pwdata[LIT_W-1:0];
				REG_CODE_WIDTH:    cfg_q.code_width    <= pwdata[CW_W-1:0];
				REG_SOURCE_SELECT: cfg_q.source_select <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_COMPARE_OP:    prdata = PDATA_W'(cfg_q.compare_op);
			REG_COMBINE_OP:    prdata = PDATA_W'(cfg_q.combine_op);
			REG_LITERAL_VALUE: prdata = PDATA_W'(cfg_q.literal_value);
			REG_CODE_WIDTH:    prdata = PDATA_W'(cfg_q.code_width);
			REG_SOURCE_SELECT: prdata = PDATA_W'(cfg_q.source_select);
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== sv/bsps_core.sv =====
// ----------------------------------------------------------------------------
// bsps_core
// Per-lane less/greater/equal masks and slice counter, with the final
// predicate, combine and lane clearing for the last slice of a segment.
// ----------------------------------------------------------------------------
module bsps_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsps_pkg::cfg_t                 cfg,
	input  logic                           step,
	input  logic [bsps_pkg::WORD_W-1:0]    data_slice,
	input  logic [bsps_pkg::WORD_W-1:0]    other_slice,
	input  logic [bsps_pkg::WORD_W-1:0]    prior_bits,
	input  logic [bsps_pkg::VALID_W-1:0]   valid_lanes,
	output logic                           last,
	output logic [bsps_pkg::WORD_W-1:0]    result
);
	import bsps_pkg::*;

	logic [WORD_W-1:0]  lt_q, gt_q, eq_q;
	logic [SLICE_W-1:0] slice_q;

	logic [CW_W-1:0]    width_eff;
	logic [CW_W-1:0]    idx_ext;
	logic [SLICE_W-1:0] lit_pos;
	logic               first;
	logic [WORD_W-1:0]  eq_seed, lt_base, gt_base, eq_base;
	logic [WORD_W-1:0]  other;
	logic [WORD_W-1:0]  lt_n, gt_n, eq_n;
	logic [WORD_W-1:0]  pred, combined, lane_mask;

	assign idx_ext = CW_W'(slice_q);
	assign first   = (slice_q == '0);

	always_comb begin
		if (cfg.code_width == '0)
			width_eff = CW_W'(1);
		else if (cfg.code_width > CODE_WIDTH_RESET)
			width_eff = CODE_WIDTH_RESET;
		else
			width_eff = cfg.code_width;
	end

	assign last    = (idx_ext + CW_W'(1)) >= width_eff;
	assign lit_pos = SLICE_W'(width_eff - CW_W'(1) - idx_ext);

	always_comb begin
		unique case (cfg.combine_op)
			CMB_AND: eq_seed = prior_bits;
			CMB_OR:  eq_seed = ~prior_bits;
			default: eq_seed = '1;
		endcase
	end

	assign lt_base = first ? '0 : lt_q;
	assign gt_base = first ? '0 : gt_q;
	assign eq_base = first ? eq_seed : eq_q;

	// When the width was lowered under the running slice count, the literal
	// bit reads as zero.
	always_comb begin
		if (cfg.source_select)
			other = other_slice;
		else if (idx_ext < width_eff)
			other = {WORD_W{cfg.literal_value[lit_pos]}};
		else
			other = '0;
	end

	assign lt_n = lt_base | (eq_base & ~data_slice & other);
	assign gt_n = gt_base | (eq_base & data_slice & ~other);
	assign eq_n = eq_base & ~(data_slice ^ other);

	always_comb begin
		unique case (cfg.compare_op)
			CMP_LT:  pred = lt_n;
			CMP_GT:  pred = gt_n;
			CMP_LE:  pred = lt_n | eq_n;
			CMP_GE:  pred = gt_n | eq_n;
			CMP_EQ:  pred = eq_n;
			CMP_NE:  pred = ~eq_n;
			default: pred = '0;
		endcase
	end

	always_comb begin
		unique case (cfg.combine_op)
			CMB_AND: combined = pred & prior_bits;
			CMB_OR:  combined = pred | prior_bits;
			default: combined = pred;
		endcase
	end

	always_comb begin
		for (int i = 0; i < WORD_W; i++)
			lane_mask[i] = (i < LANES) && (VALID_W'(i) < valid_lanes);
	end

	assign result = combined & lane_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q    <= '0;
			gt_q    <= '0;
			eq_q    <= '0;
			slice_q <= '0;
		end else if (step) begin
			lt_q <= lt_n;
			gt_q <= gt_n;
			eq_q <= eq_n;
			if (last)
				slice_q <= '0;
			else
				slice_q <= SLICE_W'(idx_ext + CW_W'(1));
		end
	end

endmodule

// ===== sv/bit_sliced_predicate_scan.sv =====
// ----------------------------------------------------------------------------
// bit_sliced_predicate_scan
// Predicate scan over vertical bit slices of a segment of column codes.
// ----------------------------------------------------------------------------
// One bit slice is taken per clock cycle, most significant slice first, and
// code_width slices make one segment. An accepted slice is held in the
// input register and is folded into the lane masks at the edge at which it
// advances; on the last slice of a segment the result word is loaded into
// the output register at that same edge and is offered from there. The
// input side stalls only while a finished result waits in the output
// register and the slice in the input register would produce the next one.
module bit_sliced_predicate_scan (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsps_pkg::ADDR_W-1:0]    paddr,
	input  logic [bsps_pkg::PDATA_W-1:0]   pwdata,
	output logic [bsps_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bsps_pkg::WORD_W-1:0]    data_slice,
	input  logic [bsps_pkg::WORD_W-1:0]    other_slice,
	input  logic [bsps_pkg::WORD_W-1:0]    prior_bits,
	input  logic [bsps_pkg::VALID_W-1:0]   valid_lanes,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bsps_pkg::WORD_W-1:0]    result_bits
);
	import bsps_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	logic [WORD_W-1:0]  data_slice_s1, other_slice_s1, prior_bits_s1;
	logic [VALID_W-1:0] valid_lanes_s1;
	logic               out_valid_q;
	logic [WORD_W-1:0]  result_bits_q;
	logic               core_last;
	logic [WORD_W-1:0]  core_result;
	logic               advance;
	logic               in_accept;

	bsps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsps_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (advance),
		.data_slice  (data_slice_s1),
		.other_slice (other_slice_s1),
		.prior_bits  (prior_bits_s1),
		.valid_lanes (valid_lanes_s1),
		.last        (core_last),
		.result      (core_result)
	);

	// The held slice moves on unless it finishes a segment while the
	// output register is full and stalled.
	assign advance   = valid_s1 && !(core_last && out_valid_q && out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_slice_s1  <= data_slice;
			other_slice_s1 <= other_slice;
			prior_bits_s1  <= prior_bits;
			valid_lanes_s1 <= valid_lanes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && core_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_last)
			result_bits_q <= core_result;
	end

	assign out_valid   = out_valid_q;
	assign result_bits = result_bits_q;

endmodule

// ===== sv/bsps_checker.sv =====
// ----------------------------------------------------------------------------
// bsps_checker
// Port-level checks of the bit-sliced predicate scan, bound to the top level.
// ----------------------------------------------------------------------------
module bsps_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bsps_pkg::ADDR_W-1:0]    paddr,
	input  logic [bsps_pkg::PDATA_W-1:0]   pwdata,
	input  logic [bsps_pkg::PDATA_W-1:0]   prdata,
	input  logic                           in_stall,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [bsps_pkg::WORD_W-1:0]    result_bits
);
	import bsps_pkg::*;

	// A pending result stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result does not change.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(result_bits))
		else $error("result changed while stalled");

	// The input side only stalls behind a full, stalled output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// A literal written is read back at the same address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_LITERAL_VALUE)
		##1 (paddr[ADDR_W-1:2] == REG_LITERAL_VALUE)
		|-> prdata == $past(pwdata))
		else $error("literal register readback mismatch");

endmodule

bind bit_sliced_predicate_scan bsps_checker u_bsps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.pwdata      (pwdata),
	.prdata      (prdata),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_bits (result_bits)
);
